// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the ecc naf core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds in the same cycle as its trigger
`define ECC_ASSERT_SAME(lbl, clk_s, rst_s, trig, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |-> (prop)) \
        else $error(msg);

// property holds in the cycle after its trigger
`define ECC_ASSERT_NEXT(lbl, clk_s, rst_s, trig, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/ecc_naf_pkg.sv =====
// shared types, constants and field helpers of the ecc naf scalar multiplier
package ecc_naf_pkg;

    localparam int FIELD_BITS  = 16;
    localparam int SCALAR_BITS = 32;
    localparam int NAF_LEN     = SCALAR_BITS + 1;
    localparam int NAF_IDX_W   = $clog2(NAF_LEN + 1);
    localparam int ALU_CNT_W   = $clog2(FIELD_BITS);

    localparam logic [0:0] REG_FIELD_MODULUS = 1'b0;
    localparam logic [0:0] REG_CURVE_A       = 1'b1;

    localparam logic [FIELD_BITS-1:0] MODULUS_RESET = FIELD_BITS'(7);
    localparam logic [FIELD_BITS-1:0] MODULUS_MIN   = FIELD_BITS'(3);

    typedef logic [FIELD_BITS-1:0] felem_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_X,
        ST_RED_X_W,
        ST_RED_Y,
        ST_RED_Y_W,
        ST_RED_A,
        ST_RED_A_W,
        ST_NAF,
        ST_PT_START,
        ST_SQ,
        ST_SQ_W,
        ST_DBL_NUM,
        ST_INV_CHK,
        ST_INV_DIV,
        ST_INV_DIV_W,
        ST_INV_MUL,
        ST_INV_MUL_W,
        ST_LAM,
        ST_LAM_W,
        ST_X3,
        ST_X3_W,
        ST_Y3,
        ST_Y3_W,
        ST_DONE
    } seq_state_t;

    // a + b mod p, operands below p
    function automatic felem_t fadd(felem_t a, felem_t b, felem_t p);
        logic [FIELD_BITS:0] s;
        logic [FIELD_BITS:0] pw;
        s  = {1'b0, a} + {1'b0, b};
        pw = {1'b0, p};
        if (s >= pw)
        begin
            fadd = FIELD_BITS'(s - pw);
        end
        else
        begin
            fadd = s[FIELD_BITS-1:0];
        end
    endfunction

    // a - b mod p, operands below p
    function automatic felem_t fsub(felem_t a, felem_t b, felem_t p);
        if (a >= b)
        begin
            fsub = a - b;
        end
        else
        begin
            fsub = a + (p - b);
        end
    endfunction

endpackage

// ===== rtl/core/ecc_naf_alu.sv =====
// shared bit-serial field multiplier and restoring divider
`include "assert_macros.svh"

module ecc_naf_alu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ecc_naf_pkg::alu_req_t    req,
    input  ecc_naf_pkg::felem_t      opa,
    input  ecc_naf_pkg::felem_t      opb,
    input  ecc_naf_pkg::felem_t      modulus,
    output ecc_naf_pkg::alu_rsp_t    rsp,
    output ecc_naf_pkg::felem_t      res_q,
    output ecc_naf_pkg::felem_t      res_r
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    ecc_naf_pkg::alu_op_t                op_reg, op_next;
    logic [ecc_naf_pkg::ALU_CNT_W-1:0]   cnt_reg, cnt_next;
    ecc_naf_pkg::felem_t                 a_reg, a_next;
    ecc_naf_pkg::felem_t                 b_reg, b_next;
    ecc_naf_pkg::felem_t                 m_reg, m_next;
    ecc_naf_pkg::felem_t                 acc_reg, acc_next;
    ecc_naf_pkg::felem_t                 rem_reg, rem_next;

    ecc_naf_pkg::felem_t                 dbl_v;
    ecc_naf_pkg::felem_t                 mul_v;
    logic [ecc_naf_pkg::FIELD_BITS:0]    sh_v;
    logic                                ge_v;

    always_comb
    begin
        // multiply step: double, then add multiplicand on a set bit
        dbl_v = ecc_naf_pkg::fadd(acc_reg, acc_reg, m_reg);
        mul_v = b_reg[ecc_naf_pkg::FIELD_BITS-1]
              ? ecc_naf_pkg::fadd(dbl_v, a_reg, m_reg) : dbl_v;
        // divide step: bring down next dividend bit
        sh_v = {rem_reg, b_reg[ecc_naf_pkg::FIELD_BITS-1]};
        ge_v = sh_v >= {1'b0, a_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        if (busy_reg)
        begin
            b_next = {b_reg[ecc_naf_pkg::FIELD_BITS-2:0], 1'b0};
            unique case (op_reg)
                ecc_naf_pkg::ALU_MUL:
                begin
                    acc_next = mul_v;
                end
                ecc_naf_pkg::ALU_DIV:
                begin
                    acc_next = {acc_reg[ecc_naf_pkg::FIELD_BITS-2:0], ge_v};
                    rem_next = ge_v ? ecc_naf_pkg::FIELD_BITS'(sh_v - {1'b0, a_reg})
                                    : sh_v[ecc_naf_pkg::FIELD_BITS-1:0];
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = ecc_naf_pkg::ALU_CNT_W'(ecc_naf_pkg::FIELD_BITS - 1);
            a_next    = opa;
            b_next    = opb;
            m_next    = modulus;
            acc_next  = '0;
            rem_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ecc_naf_pkg::ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign res_q    = acc_reg;
    assign res_r    = rem_reg;

    `ECC_ASSERT_SAME(a_done_after_busy, clk, rst_n, done_reg, $past(busy_reg),
        "alu done without a running operation")
    `ECC_ASSERT_NEXT(a_start_runs, clk, rst_n, req.start && !busy_reg, busy_reg,
        "alu start not taken")

endmodule

// ===== rtl/core/ecc_naf_scalar_multiply.sv =====
// top level: sequencer for naf scalar multiplication on a short weierstrass curve
`include "assert_macros.svh"

// Computes scalar * P on y^2 = x^3 + a*x + b over GF(p) with affine points and
// an infinity flag. One item is taken at a time: in_ready is high only while
// the sequencer is idle. The item's coordinates and the curve coefficient are
// first reduced mod p, the scalar is recoded to non-adjacent form at one digit
// per cycle, then the digits are walked from the top with a double and an
// optional add or subtract of the base point per digit. All field products,
// quotients and remainders run on one shared bit-serial unit that goes through
// a start, one step per operand bit and a done per operation. A point
// operation costs three or four products plus a Euclidean inverse that runs
// one division and one product per quotient step; a 32-bit scalar needs up to
// about 48 point operations. A zero scalar, an infinity input or a modulus
// below three skip the sequence and give infinity directly. The finished
// result sits in an output register, so the next item may be taken while
// it waits. field_modulus and curve_a are written through
// cfg_we/cfg_index/cfg_data and must only change while the block is idle.

module ecc_naf_scalar_multiply (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [0:0]                             cfg_index,
    input  logic [ecc_naf_pkg::FIELD_BITS-1:0]     cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [ecc_naf_pkg::FIELD_BITS-1:0]     point_x,
    input  logic [ecc_naf_pkg::FIELD_BITS-1:0]     point_y,
    input  logic                                   point_is_infinity,
    input  logic [ecc_naf_pkg::SCALAR_BITS-1:0]    scalar,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [ecc_naf_pkg::FIELD_BITS-1:0]     out_x,
    output logic [ecc_naf_pkg::FIELD_BITS-1:0]     out_y,
    output logic                                   out_is_infinity
);

    localparam int KW = ecc_naf_pkg::SCALAR_BITS + 1;
    localparam int IW = ecc_naf_pkg::NAF_IDX_W;

    // configuration registers
    ecc_naf_pkg::felem_t        p_reg;
    ecc_naf_pkg::felem_t        acfg_reg;

    // sequencer state
    ecc_naf_pkg::seq_state_t    state_reg, state_next;
    logic [IW-1:0]              n_reg, n_next;          // digit count
    logic [IW-1:0]              i_reg, i_next;          // current digit
    logic                       addph_reg, addph_next;  // add half of a digit
    logic                       qinf_reg, qinf_next;
    logic                       ovld_reg, ovld_next;

    // datapath
    logic [KW-1:0]                      k_reg, k_next;
    logic [ecc_naf_pkg::NAF_LEN-1:0]    nz_reg, nz_next;
    logic [ecc_naf_pkg::NAF_LEN-1:0]    ng_reg, ng_next;
    ecc_naf_pkg::felem_t        ared_reg, ared_next;
    ecc_naf_pkg::felem_t        bx_reg, bx_next;
    ecc_naf_pkg::felem_t        by_reg, by_next;
    ecc_naf_pkg::felem_t        qx_reg, qx_next;
    ecc_naf_pkg::felem_t        qy_reg, qy_next;
    ecc_naf_pkg::felem_t        num_reg, num_next;
    ecc_naf_pkg::felem_t        tmp_reg, tmp_next;
    ecc_naf_pkg::felem_t        r0_reg, r0_next;
    ecc_naf_pkg::felem_t        r1_reg, r1_next;
    ecc_naf_pkg::felem_t        ey_reg, ey_next;
    ecc_naf_pkg::felem_t        ev_reg, ev_next;
    ecc_naf_pkg::felem_t        quo_reg, quo_next;
    ecc_naf_pkg::felem_t        rem_reg, rem_next;
    ecc_naf_pkg::felem_t        lam_reg, lam_next;
    ecc_naf_pkg::felem_t        ox_reg, ox_next;
    ecc_naf_pkg::felem_t        oy_reg, oy_next;
    logic                       oinf_reg, oinf_next;

    // shared unit
    ecc_naf_pkg::alu_req_t      alu_req;
    ecc_naf_pkg::alu_rsp_t      alu_rsp;
    ecc_naf_pkg::felem_t        alu_a;
    ecc_naf_pkg::felem_t        alu_b;
    ecc_naf_pkg::felem_t        alu_q;
    ecc_naf_pkg::felem_t        alu_r;

    // per-digit helpers
    logic                       dig_nz;
    logic                       dig_neg;
    ecc_naf_pkg::felem_t        nby;
    ecc_naf_pkg::felem_t        q2x;
    ecc_naf_pkg::felem_t        q2y;
    ecc_naf_pkg::felem_t        neg_q2y;
    logic [KW-1:0]              k_adj;
    logic                       in_beat;
    logic                       out_beat;

    ecc_naf_alu u_alu (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (alu_req),
        .opa     (alu_a),
        .opb     (alu_b),
        .modulus (p_reg),
        .rsp     (alu_rsp),
        .res_q   (alu_q),
        .res_r   (alu_r)
    );

    assign in_ready = (state_reg == ecc_naf_pkg::ST_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_beat = ovld_reg && out_ready;

    always_comb
    begin
        dig_nz  = nz_reg[i_reg];
        dig_neg = ng_reg[i_reg];
        nby     = ecc_naf_pkg::fsub('0, by_reg, p_reg);
        // second operand: Q itself when doubling, +/-B when adding
        q2x     = addph_reg ? bx_reg : qx_reg;
        q2y     = addph_reg ? (dig_neg ? nby : by_reg) : qy_reg;
        neg_q2y = ecc_naf_pkg::fsub('0, q2y, p_reg);
        // naf digit: odd k moves to the nearest multiple of four
        if (k_reg[0])
        begin
            k_adj = k_reg[1] ? (k_reg + 1'b1) : (k_reg - 1'b1);
        end
        else
        begin
            k_adj = k_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        addph_next = addph_reg;
        qinf_next  = qinf_reg;
        k_next     = k_reg;
        nz_next    = nz_reg;
        ng_next    = ng_reg;
        ared_next  = ared_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        num_next   = num_reg;
        tmp_next   = tmp_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        ey_next    = ey_reg;
        ev_next    = ev_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        lam_next   = lam_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oinf_next  = oinf_reg;
        ovld_next  = out_beat ? 1'b0 : ovld_reg;
        alu_req    = '{start: 1'b0, op: ecc_naf_pkg::ALU_MUL};
        alu_a      = '0;
        alu_b      = '0;

        unique case (state_reg)
            ecc_naf_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    bx_next = point_x;
                    by_next = point_y;
                    k_next  = {1'b0, scalar};
                    n_next  = '0;
                    nz_next = '0;
                    ng_next = '0;
                    if (p_reg < ecc_naf_pkg::MODULUS_MIN || point_is_infinity
                        || scalar == '0)
                    begin
                        qinf_next  = 1'b1;
                        state_next = ecc_naf_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ecc_naf_pkg::ST_RED_X;
                    end
                end
            end
            ecc_naf_pkg::ST_RED_X:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_DIV};
                alu_a      = p_reg;
                alu_b      = bx_reg;
                state_next = ecc_naf_pkg::ST_RED_X_W;
            end
            ecc_naf_pkg::ST_RED_X_W:
            begin
                if (alu_rsp.done)
                begin
                    bx_next    = alu_r;
                    state_next = ecc_naf_pkg::ST_RED_Y;
                end
            end
            ecc_naf_pkg::ST_RED_Y:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_DIV};
                alu_a      = p_reg;
                alu_b      = by_reg;
                state_next = ecc_naf_pkg::ST_RED_Y_W;
            end
            ecc_naf_pkg::ST_RED_Y_W:
            begin
                if (alu_rsp.done)
                begin
                    by_next    = alu_r;
                    state_next = ecc_naf_pkg::ST_RED_A;
                end
            end
            ecc_naf_pkg::ST_RED_A:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_DIV};
                alu_a      = p_reg;
                alu_b      = acfg_reg;
                state_next = ecc_naf_pkg::ST_RED_A_W;
            end
            ecc_naf_pkg::ST_RED_A_W:
            begin
                if (alu_rsp.done)
                begin
                    ared_next  = alu_r;
                    state_next = ecc_naf_pkg::ST_NAF;
                end
            end
            ecc_naf_pkg::ST_NAF:
            begin
                if (k_reg == '0)
                begin
                    // leading digit is +1: start from the base point
                    qx_next    = bx_reg;
                    qy_next    = by_reg;
                    qinf_next  = 1'b0;
                    addph_next = 1'b0;
                    i_next     = n_reg - IW'(2);
                    if (n_reg == IW'(1))
                    begin
                        state_next = ecc_naf_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = ecc_naf_pkg::ST_PT_START;
                    end
                end
                else
                begin
                    nz_next[n_reg] = k_reg[0];
                    ng_next[n_reg] = k_reg[0] && k_reg[1];
                    k_next         = k_adj >> 1;
                    n_next         = n_reg + 1'b1;
                end
            end
            ecc_naf_pkg::ST_PT_START:
            begin
                r0_next = p_reg;
                ey_next = '0;
                ev_next = ecc_naf_pkg::felem_t'(1);
                if (qinf_reg)
                begin
                    // infinity absorbs a double; an add yields the operand
                    if (addph_reg)
                    begin
                        qx_next   = q2x;
                        qy_next   = q2y;
                        qinf_next = 1'b0;
                    end
                    state_next = ecc_naf_pkg::ST_Y3_W;
                end
                else if (qx_reg == q2x && qy_reg == neg_q2y)
                begin
                    qinf_next  = 1'b1;
                    state_next = ecc_naf_pkg::ST_Y3_W;
                end
                else if (qx_reg != q2x)
                begin
                    num_next   = ecc_naf_pkg::fsub(qy_reg, q2y, p_reg);
                    r1_next    = ecc_naf_pkg::fsub(qx_reg, q2x, p_reg);
                    state_next = ecc_naf_pkg::ST_INV_CHK;
                end
                else
                begin
                    // tangent slope, also used for equal x off the curve
                    r1_next    = ecc_naf_pkg::fadd(qy_reg, qy_reg, p_reg);
                    state_next = ecc_naf_pkg::ST_SQ;
                end
            end
            ecc_naf_pkg::ST_SQ:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_MUL};
                alu_a      = qx_reg;
                alu_b      = qx_reg;
                state_next = ecc_naf_pkg::ST_SQ_W;
            end
            ecc_naf_pkg::ST_SQ_W:
            begin
                if (alu_rsp.done)
                begin
                    tmp_next   = alu_q;
                    num_next   = ecc_naf_pkg::fadd(alu_q, alu_q, p_reg);
                    state_next = ecc_naf_pkg::ST_DBL_NUM;
                end
            end
            ecc_naf_pkg::ST_DBL_NUM:
            begin
                num_next   = ecc_naf_pkg::fadd(ecc_naf_pkg::fadd(num_reg, tmp_reg, p_reg),
                                               ared_reg, p_reg);
                state_next = ecc_naf_pkg::ST_INV_CHK;
            end
            ecc_naf_pkg::ST_INV_CHK:
            begin
                // euclid ends on a zero remainder; ey holds the cofactor
                if (r1_reg == '0)
                begin
                    state_next = ecc_naf_pkg::ST_LAM;
                end
                else
                begin
                    state_next = ecc_naf_pkg::ST_INV_DIV;
                end
            end
            ecc_naf_pkg::ST_INV_DIV:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_DIV};
                alu_a      = r1_reg;
                alu_b      = r0_reg;
                state_next = ecc_naf_pkg::ST_INV_DIV_W;
            end
            ecc_naf_pkg::ST_INV_DIV_W:
            begin
                if (alu_rsp.done)
                begin
                    // quotient never exceeds p, so mod p is one compare
                    quo_next   = (alu_q == p_reg) ? '0 : alu_q;
                    rem_next   = alu_r;
                    state_next = ecc_naf_pkg::ST_INV_MUL;
                end
            end
            ecc_naf_pkg::ST_INV_MUL:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_MUL};
                alu_a      = ev_reg;
                alu_b      = quo_reg;
                state_next = ecc_naf_pkg::ST_INV_MUL_W;
            end
            ecc_naf_pkg::ST_INV_MUL_W:
            begin
                if (alu_rsp.done)
                begin
                    ev_next    = ecc_naf_pkg::fsub(ey_reg, alu_q, p_reg);
                    ey_next    = ev_reg;
                    r0_next    = r1_reg;
                    r1_next    = rem_reg;
                    state_next = ecc_naf_pkg::ST_INV_CHK;
                end
            end
            ecc_naf_pkg::ST_LAM:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_MUL};
                alu_a      = num_reg;
                alu_b      = ey_reg;
                state_next = ecc_naf_pkg::ST_LAM_W;
            end
            ecc_naf_pkg::ST_LAM_W:
            begin
                if (alu_rsp.done)
                begin
                    lam_next   = alu_q;
                    state_next = ecc_naf_pkg::ST_X3;
                end
            end
            ecc_naf_pkg::ST_X3:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_MUL};
                alu_a      = lam_reg;
                alu_b      = lam_reg;
                state_next = ecc_naf_pkg::ST_X3_W;
            end
            ecc_naf_pkg::ST_X3_W:
            begin
                if (alu_rsp.done)
                begin
                    tmp_next   = ecc_naf_pkg::fsub(ecc_naf_pkg::fsub(alu_q, qx_reg, p_reg),
                                                   q2x, p_reg);
                    state_next = ecc_naf_pkg::ST_Y3;
                end
            end
            ecc_naf_pkg::ST_Y3:
            begin
                alu_req    = '{start: 1'b1, op: ecc_naf_pkg::ALU_MUL};
                alu_a      = lam_reg;
                alu_b      = ecc_naf_pkg::fsub(qx_reg, tmp_reg, p_reg);
                state_next = ecc_naf_pkg::ST_Y3_W;
            end
            ecc_naf_pkg::ST_Y3_W:
            begin
                // also reached directly from the special cases of point start
                if (alu_rsp.done || !alu_rsp.busy)
                begin
                    if (alu_rsp.done)
                    begin
                        qx_next   = tmp_reg;
                        qy_next   = ecc_naf_pkg::fsub(alu_q, qy_reg, p_reg);
                        qinf_next = 1'b0;
                    end
                    if (!addph_reg && dig_nz)
                    begin
                        addph_next = 1'b1;
                        state_next = ecc_naf_pkg::ST_PT_START;
                    end
                    else if (i_reg == '0)
                    begin
                        state_next = ecc_naf_pkg::ST_DONE;
                    end
                    else
                    begin
                        addph_next = 1'b0;
                        i_next     = i_reg - 1'b1;
                        state_next = ecc_naf_pkg::ST_PT_START;
                    end
                end
            end
            ecc_naf_pkg::ST_DONE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next  = 1'b1;
                    oinf_next  = qinf_reg;
                    ox_next    = qinf_reg ? '0 : qx_reg;
                    oy_next    = qinf_reg ? '0 : qy_reg;
                    state_next = ecc_naf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ecc_naf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg     <= ecc_naf_pkg::MODULUS_RESET;
            acfg_reg  <= '0;
            state_reg <= ecc_naf_pkg::ST_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            addph_reg <= 1'b0;
            qinf_reg  <= 1'b0;
            ovld_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ecc_naf_pkg::REG_FIELD_MODULUS: p_reg    <= cfg_data;
                    ecc_naf_pkg::REG_CURVE_A:       acfg_reg <= cfg_data;
                    default:                        p_reg    <= p_reg;
                endcase
            end
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            addph_reg <= addph_next;
            qinf_reg  <= qinf_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        nz_reg   <= nz_next;
        ng_reg   <= ng_next;
        ared_reg <= ared_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        qx_reg   <= qx_next;
        qy_reg   <= qy_next;
        num_reg  <= num_next;
        tmp_reg  <= tmp_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        ey_reg   <= ey_next;
        ev_reg   <= ev_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        lam_reg  <= lam_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oinf_reg <= oinf_next;
    end

    assign out_valid       = ovld_reg;
    assign out_x           = ox_reg;
    assign out_y           = oy_reg;
    assign out_is_infinity = oinf_reg;

    `ECC_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_beat, !in_ready,
        "new beat taken while an item is in flight")
    `ECC_ASSERT_SAME(a_inf_zero, clk, rst_n, ovld_reg && oinf_reg,
        ox_reg == '0 && oy_reg == '0, "infinity result with nonzero coordinates")
    `ECC_ASSERT_SAME(a_no_start_busy, clk, rst_n, alu_req.start, !alu_rsp.busy,
        "shared unit started while running")

endmodule

// ===== verif/ecc_naf_checker.sv =====
// checker for the ecc naf scalar multiplier: predicts and compares result beats
`timescale 1ns / 100ps

module ecc_naf_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] point_x,
    input  logic [15:0] point_y,
    input  logic        point_is_infinity,
    input  logic [31:0] scalar,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_x,
    input  logic [15:0] out_y,
    input  logic        out_is_infinity,
    output int          fail_count,
    output int          pending
);

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic        inf;
    } ec_point_t;

    logic [15:0] modulus;
    logic [15:0] coef_a;
    ec_point_t   product_q[$];

    function automatic logic [15:0] mod_sum(logic [31:0] a, logic [31:0] b, logic [31:0] p);
        return 16'((a + b) % p);
    endfunction

    function automatic logic [15:0] mod_diff(logic [31:0] a, logic [31:0] b, logic [31:0] p);
        return (a >= b) ? 16'(a - b) : 16'(a + (p - b));
    endfunction

    function automatic logic [15:0] mod_prod(logic [63:0] a, logic [63:0] b, logic [63:0] p);
        return 16'((a * b) % p);
    endfunction

    // euclid on (p, den), cofactor of den kept mod p
    function automatic logic [15:0] euclid_inverse(logic [31:0] den, logic [31:0] p);
        logic [31:0] r0, r1, quo, nr;
        logic [15:0] cy, cv, nv;
        r0 = p;
        r1 = den;
        cy = 0;
        cv = 16'(1 % p);
        while (r1 > 0)
        begin
            quo = r0 / r1;
            nv  = mod_diff(cy, mod_prod(quo % p, cv, p), p);
            nr  = r0 - quo * r1;
            cy  = cv;
            cv  = nv;
            r0  = r1;
            r1  = nr;
        end
        return cy;
    endfunction

    function automatic ec_point_t point_add(ec_point_t pa, ec_point_t pb, logic [15:0] a,
                                            logic [15:0] p);
        ec_point_t   r;
        logic [15:0] num, den, lam, x3, xx;
        if (pa.inf)
            return pb;
        if (pb.inf)
            return pa;
        if (pa.x == pb.x && pa.y == mod_diff(0, pb.y, p))
        begin
            r.x = 0;
            r.y = 0;
            r.inf = 1'b1;
            return r;
        end
        if (pa.x != pb.x)
        begin
            num = mod_diff(pa.y, pb.y, p);
            den = mod_diff(pa.x, pb.x, p);
        end
        else
        begin
            // same x: doubling slope taken from the first operand
            xx  = mod_prod(pa.x, pa.x, p);
            num = mod_sum(mod_sum(mod_sum(xx, xx, p), xx, p), a, p);
            den = mod_sum(pa.y, pa.y, p);
        end
        lam = mod_prod(num, euclid_inverse(den, p), p);
        x3  = mod_diff(mod_diff(mod_prod(lam, lam, p), pa.x, p), pb.x, p);
        r.y = mod_diff(mod_prod(lam, mod_diff(pa.x, x3, p), p), pa.y, p);
        r.x = x3;
        r.inf = 1'b0;
        return r;
    endfunction

    function automatic ec_point_t scalar_product(logic [15:0] px, logic [15:0] py, logic pinf,
                                                 logic [31:0] k_in, logic [15:0] p,
                                                 logic [15:0] a_raw);
        ec_point_t   base, neg, acc;
        logic [63:0] k;
        logic [15:0] a;
        int          digit[0:40];
        int          n;
        acc.x = 0;
        acc.y = 0;
        acc.inf = 1'b1;
        if (p < 3 || pinf || k_in == 0)
            return acc;
        a = a_raw % p;
        base.x = px % p;
        base.y = py % p;
        base.inf = 1'b0;
        neg = base;
        neg.y = mod_diff(0, base.y, p);
        // naf digits, least significant first
        k = k_in;
        n = 0;
        while (k != 0)
        begin
            digit[n] = 0;
            if (k[0])
            begin
                if (k[1:0] == 2'b01)
                begin
                    digit[n] = 1;
                    k = k - 1;
                end
                else
                begin
                    digit[n] = -1;
                    k = k + 1;
                end
            end
            n++;
            k = k >> 1;
        end
        acc = base;
        for (int i = n - 2; i >= 0; i--)
        begin
            acc = point_add(acc, acc, a, p);
            if (digit[i] < 0)
                acc = point_add(acc, neg, a, p);
            else if (digit[i] > 0)
                acc = point_add(acc, base, a, p);
        end
        if (acc.inf)
        begin
            acc.x = 0;
            acc.y = 0;
        end
        return acc;
    endfunction

    assign pending = product_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        ec_point_t want;
        if (!rst_n)
        begin
            modulus <= ecc_naf_pkg::MODULUS_RESET;
            coef_a <= '0;
            fail_count <= 0;
            product_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == ecc_naf_pkg::REG_FIELD_MODULUS)
                    modulus <= cfg_data;
                else if (cfg_index == ecc_naf_pkg::REG_CURVE_A)
                    coef_a <= cfg_data;
            end
            if (in_valid && in_ready)
                product_q.push_back(scalar_product(point_x, point_y, point_is_infinity,
                                                   scalar, modulus, coef_a));
            if (out_valid && out_ready)
            begin
                if (product_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: x=%h y=%h inf=%b",
                             $time, out_x, out_y, out_is_infinity);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = product_q.pop_front();
                    if (want.x !== out_x || want.y !== out_y || want.inf !== out_is_infinity)
                    begin
                        $display("%0t: mismatch expected x=%h y=%h inf=%b actual x=%h y=%h inf=%b",
                                 $time, want.x, want.y, want.inf, out_x, out_y,
                                 out_is_infinity);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
// top of the ecc naf scalar multiplier testbench: stimulus, stalls and verdict
`timescale 1ns / 100ps

module testbench;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        point_is_infinity;
    logic [31:0] scalar;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        out_is_infinity;
    int          fail_count;
    int          pending;

    // percent chance of a sender gap / receiver stall per cycle
    int          gap_pct;
    int          stall_pct;
    logic [15:0] cur_mod;

    ecc_naf_scalar_multiply u_top (.*);

    ecc_naf_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // receiver: stalls at random while stall_pct is nonzero
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // one input beat: optional random gap, then hold valid until accepted
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic inf, logic [31:0] k);
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_is_infinity <= inf;
        scalar <= k;
        // in_ready is stable between the falling edge and the next rising edge
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
    endtask

    // hold off the sender until every expected result beat has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // register write, only issued with the block idle
    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == ecc_naf_pkg::REG_FIELD_MODULUS)
            cur_mod = value;
    endtask

    // mostly short scalars to keep the run time sane, a few full width
    function automatic logic [31:0] pick_scalar();
        case ($urandom_range(9))
            0: return $urandom();
            1: return $urandom_range(65535);
            default: return $urandom_range(255);
        endcase
    endfunction

    function automatic logic [15:0] pick_coord();
        if (cur_mod < 3 || $urandom_range(9) == 0)
            return 16'($urandom());
        return 16'($urandom_range(cur_mod - 1));
    endfunction

    task automatic random_phase(int items, int gp, int sp, logic [15:0] p, logic [15:0] a);
        drain();
        gap_pct = gp;
        stall_pct = sp;
        write_reg(ecc_naf_pkg::REG_FIELD_MODULUS, p);
        write_reg(ecc_naf_pkg::REG_CURVE_A, a);
        for (int i = 0; i < items; i++)
            send_point(pick_coord(), pick_coord(), ($urandom_range(19) == 0), pick_scalar());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        point_is_infinity = 1'b0;
        scalar = '0;
        gap_pct = 0;
        stall_pct = 0;
        cur_mod = ecc_naf_pkg::MODULUS_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at reset settings (p = 7, a = 0)
        send_point(16'd3, 16'd1, 1'b0, 32'd0);             // zero scalar
        send_point(16'd3, 16'd1, 1'b1, 32'd5);             // infinity input
        send_point(16'd3, 16'd1, 1'b0, 32'd1);
        send_point(16'd2, 16'd0, 1'b0, 32'd2);             // doubling a point with y = 0
        send_point(16'hffff, 16'hffff, 1'b0, 32'd3);       // unreduced coordinates
        send_point(16'd5, 16'd4, 1'b0, 32'hffffffff);
        send_point(16'd1, 16'd6, 1'b0, 32'h80000000);

        // modulus below three gives infinity
        drain();
        write_reg(ecc_naf_pkg::REG_FIELD_MODULUS, 16'd0);
        send_point(16'd1, 16'd1, 1'b0, 32'd7);
        drain();
        write_reg(ecc_naf_pkg::REG_FIELD_MODULUS, 16'd2);
        send_point(16'd1, 16'd1, 1'b0, 32'd7);

        // largest composite modulus and largest coefficient
        drain();
        write_reg(ecc_naf_pkg::REG_FIELD_MODULUS, 16'hffff);
        write_reg(ecc_naf_pkg::REG_CURVE_A, 16'hffff);
        send_point(16'hfffe, 16'h1234, 1'b0, 32'd11);
        send_point(16'h0000, 16'h0000, 1'b0, 32'd6);       // y = 0 doubles to infinity
        send_point(16'habcd, 16'h5555, 1'b0, 32'haaaaaaaa);

        // smallest modulus
        drain();
        write_reg(ecc_naf_pkg::REG_FIELD_MODULUS, 16'd3);
        write_reg(ecc_naf_pkg::REG_CURVE_A, 16'd2);
        send_point(16'd0, 16'd1, 1'b0, 32'd2);
        send_point(16'd2, 16'd2, 1'b0, 32'd13);

        // random phases, one idling style each
        random_phase(25, 0, 0, 16'd65521, 16'd3);
        random_phase(25, 59, 0, 16'd251, 16'd0);
        random_phase(25, 0, 59, 16'd97, 16'hffff);
        random_phase(25, 25, 25, 16'd65519, 16'd7);

        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #300_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
